### hdl/aef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aef_pkg
// shared constants, types and arithmetic helpers of the feedback echo block
// ----------------------------------------------------------------------------
package aef_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int DELAY_DEPTH = 8192;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int SUM_W       = SAMPLE_W + 3;

	localparam logic [CNT_W-1:0] DELAY_RESET = CNT_W'(4800);
	localparam logic [CNT_W-1:0] DELAY_MAX   = CNT_W'(DELAY_DEPTH);
	localparam logic [CNT_W-1:0] DELAY_MIN   = CNT_W'(1);

	// ceil(2^20 / 5), exact quotient for magnitudes below 2^18
	localparam logic [19:0] DIV5_RECIP = 20'd209716;
	// sqrt(5) in q16
	localparam logic [17:0] SQRT5_Q16  = 18'd146543;

	localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7fff;
	localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

	// control from the top level to each channel lane
	typedef struct packed {
		logic              acc;        // input transfer this cycle
		logic              adv1;       // stage 1 item moves on (and writes the line)
		logic              warm_s1;    // echo tap in use for the stage 1 item
		logic [ADDR_W-1:0] wr_addr_s1; // line position of the stage 1 item
		logic [ADDR_W-1:0] rd_addr;    // tap position of the incoming item
	} aef_ctrl_t;

	// signed sum divided by five, truncated toward zero
	function automatic logic [SAMPLE_W-1:0] div5(input logic [SUM_W-1:0] s);
		logic [SUM_W-2:0]    mag;
		logic [SUM_W+18:0]   prod;
		logic [SAMPLE_W:0]   q;
		logic [SAMPLE_W:0]   r;
		mag  = s[SUM_W-1] ? (SUM_W-1)'(~s + SUM_W'(1)) : s[SUM_W-2:0];
		prod = (SUM_W+19)'(mag) * (SUM_W+19)'(DIV5_RECIP);
		q    = prod[SAMPLE_W+20:20];
		r    = s[SUM_W-1] ? (~q + (SAMPLE_W+1)'(1)) : q;
		return r[SAMPLE_W-1:0];
	endfunction

	// signed sample times sqrt(5), truncated toward zero and saturated
	function automatic logic [SAMPLE_W-1:0] amplify(input logic [SAMPLE_W-1:0] m);
		logic [SAMPLE_W:0]    mag;
		logic [SAMPLE_W+18:0] prod;
		logic [SAMPLE_W+2:0]  t;
		logic [SAMPLE_W+2:0]  neg;
		logic [SAMPLE_W-1:0]  r;
		mag  = m[SAMPLE_W-1] ? (SAMPLE_W+1)'(~{m[SAMPLE_W-1], m} + (SAMPLE_W+1)'(1))
		                     : {1'b0, m};
		prod = (SAMPLE_W+19)'(mag) * (SAMPLE_W+19)'(SQRT5_Q16);
		t    = prod[SAMPLE_W+18:16];
		neg  = ~t + (SAMPLE_W+3)'(1);
		if (!m[SAMPLE_W-1]) begin
			r = (t > (SAMPLE_W+3)'(SAT_POS)) ? SAT_POS : t[SAMPLE_W-1:0];
		end else begin
			r = (t > (SAMPLE_W+3)'(SAT_NEG)) ? SAT_NEG : neg[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/audio_feedback_echo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_feedback_echo
// two-channel feedback comb filter echo with sqrt(5) output gain
// ----------------------------------------------------------------------------
// Takes one stereo frame per transfer and returns one frame per transfer, in
// order, at a sustained rate of one frame per clock cycle while the output
// side accepts. A frame passes three register stages: the delay line read,
// the mix and line write, then the gain into the output register, whose
// valid flag is output valid and holds the frame until it is taken.
// Each channel has its own lane with an 8192 x 16 delay line in one memory
// that is read and written once per cycle; a tap that lands on the entry
// being written in the same cycle is forwarded. Until echo_delay frames have
// gone through, the mixed value is the input itself, so the line needs no
// clearing after reset. echo_delay is taken as 1 when written as 0 and as
// 8192 above that; write it only while the block is idle.
// ----------------------------------------------------------------------------
module audio_feedback_echo (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               echo_delay_we,
	input  wire logic [aef_pkg::CNT_W-1:0]          echo_delay_wdata,
	// input frames
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [2*aef_pkg::SAMPLE_W-1:0]     s_tdata,  // sample_ch0, sample_ch1
	// output frames
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [2*aef_pkg::SAMPLE_W-1:0]          m_tdata   // out_ch0, out_ch1
);

	// configuration and line bookkeeping
	logic [aef_pkg::CNT_W-1:0]  delay_q;
	logic [aef_pkg::ADDR_W-1:0] wr_idx_q;
	logic [aef_pkg::CNT_W-1:0]  warm_q;

	// pipeline control
	logic                       v1_s1;
	logic                       v2_s2;
	logic                       warm_s1;
	logic [aef_pkg::ADDR_W-1:0] wr_addr_s1;

	logic [aef_pkg::CNT_W-1:0]    eff_delay;
	logic                         acc;
	logic                         adv1;
	logic                         adv2;
	logic                         rdy2;
	logic                         out_free;
	aef_pkg::aef_ctrl_t           ctrl;
	logic [aef_pkg::SAMPLE_W-1:0] amp_ch0;
	logic [aef_pkg::SAMPLE_W-1:0] amp_ch1;

	// zero means one, anything past the line depth means the full depth
	always_comb begin
		if (delay_q == '0) begin
			eff_delay = aef_pkg::DELAY_MIN;
		end else if (delay_q > aef_pkg::DELAY_MAX) begin
			eff_delay = aef_pkg::DELAY_MAX;
		end else begin
			eff_delay = delay_q;
		end
	end

	// each stage moves on when the one after it is empty or moving
	assign adv2     = v2_s2 && out_free;
	assign rdy2     = !v2_s2 || out_free;
	assign adv1     = v1_s1 && rdy2;
	assign s_tready = !v1_s1 || rdy2;
	assign acc      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= aef_pkg::DELAY_RESET;
		end else if (echo_delay_we) begin
			delay_q <= echo_delay_wdata;
		end
	end

	// write position wraps with the line, fill count stops at the depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			warm_q   <= '0;
		end else if (acc) begin
			wr_idx_q <= wr_idx_q + aef_pkg::ADDR_W'(1);
			if (warm_q < aef_pkg::DELAY_MAX) begin
				warm_q <= warm_q + aef_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				v1_s1 <= acc;
			end
			if (rdy2) begin
				v2_s2 <= adv1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			warm_s1    <= (warm_q >= eff_delay);
			wr_addr_s1 <= wr_idx_q;
		end
	end

	// tap sits delay frames behind the write position, modulo the depth
	always_comb begin
		ctrl.acc        = acc;
		ctrl.adv1       = adv1;
		ctrl.warm_s1    = warm_s1;
		ctrl.wr_addr_s1 = wr_addr_s1;
		ctrl.rd_addr    = wr_idx_q - eff_delay[aef_pkg::ADDR_W-1:0];
	end

	aef_lane u_lane_ch0 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (s_tdata[aef_pkg::SAMPLE_W-1:0]),
		.amp_s2 (amp_ch0)
	);

	aef_lane u_lane_ch1 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (s_tdata[2*aef_pkg::SAMPLE_W-1:aef_pkg::SAMPLE_W]),
		.amp_s2 (amp_ch1)
	);

	aef_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv2),
		.amp_ch0  (amp_ch0),
		.amp_ch1  (amp_ch1),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// fill count never passes the line depth
	a_warm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		warm_q <= aef_pkg::DELAY_MAX)
		else $error("fill count beyond line depth");

	// every input transfer moves the write position on by one
	a_wr_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (wr_idx_q == $past(wr_idx_q) + aef_pkg::ADDR_W'(1)))
		else $error("write position did not step");

	// a stalled stage 1 item blocks new input transfers
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_s1 && !adv1) |-> !acc)
		else $error("input taken over a stalled stage 1 item");

	// an accepted frame occupies stage 1 on the next cycle
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v1_s1)
		else $error("accepted frame lost before stage 1");

endmodule
`default_nettype wire

### hdl/aef_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aef_lane
// one channel: delay line memory, feedback mix and sqrt(5) gain
// ----------------------------------------------------------------------------
module aef_lane (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire aef_pkg::aef_ctrl_t               ctrl,
	input  wire logic [aef_pkg::SAMPLE_W-1:0]     sample,
	output logic      [aef_pkg::SAMPLE_W-1:0]     amp_s2
);

	logic [aef_pkg::SAMPLE_W-1:0] line_mem [aef_pkg::DELAY_DEPTH];

	logic [aef_pkg::SAMPLE_W-1:0] x_s1;
	logic [aef_pkg::SAMPLE_W-1:0] rdata_s1;
	logic [aef_pkg::SAMPLE_W-1:0] byp_s1;
	logic                         byp_hit_s1;
	logic [aef_pkg::SAMPLE_W-1:0] mix_s2;

	logic [aef_pkg::SAMPLE_W-1:0] del;
	logic [aef_pkg::SUM_W-1:0]    sum;
	logic [aef_pkg::SAMPLE_W-1:0] mix;

	// delay line: read first, so a tap at full depth sees the old entry
	always_ff @(posedge clk) begin
		if (ctrl.acc) begin
			rdata_s1 <= line_mem[ctrl.rd_addr];
		end
		if (ctrl.adv1) begin
			line_mem[ctrl.wr_addr_s1] <= mix;
		end
	end

	// tap that hits the entry written in the same cycle takes the new value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_s1 <= 1'b0;
		end else if (ctrl.acc) begin
			byp_hit_s1 <= ctrl.adv1 && (ctrl.rd_addr == ctrl.wr_addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc) begin
			x_s1   <= sample;
			byp_s1 <= mix;
		end
		if (ctrl.adv1) begin
			mix_s2 <= mix;
		end
	end

	always_comb begin
		del = byp_hit_s1 ? byp_s1 : rdata_s1;
		sum = {{3{x_s1[aef_pkg::SAMPLE_W-1]}}, x_s1}
		    + {del[aef_pkg::SAMPLE_W-1], del, 2'b00};
		mix = ctrl.warm_s1 ? aef_pkg::div5(sum) : x_s1;
	end

	assign amp_s2 = aef_pkg::amplify(mix_s2);

endmodule
`default_nettype wire

### hdl/aef_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aef_merge
// joins the channel results into one frame and holds it for the output side
// ----------------------------------------------------------------------------
module aef_merge (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             load,
	input  wire logic [aef_pkg::SAMPLE_W-1:0]     amp_ch0,
	input  wire logic [aef_pkg::SAMPLE_W-1:0]     amp_ch1,
	output logic                                  free,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [2*aef_pkg::SAMPLE_W-1:0]        m_tdata
);

	logic                          out_valid_q;
	logic [2*aef_pkg::SAMPLE_W-1:0] out_data_q;

	assign free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= {amp_ch1, amp_ch0};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

### sim/echo_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_frame_checker
// watches the frame streams of the feedback echo block, predicts each output
// frame from the accepted input frames and the delay setting, and compares
// ----------------------------------------------------------------------------
module echo_frame_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           delay_we,
	input  wire logic [aef_pkg::CNT_W-1:0]      delay_wdata,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [2*aef_pkg::SAMPLE_W-1:0] s_tdata,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [2*aef_pkg::SAMPLE_W-1:0] m_tdata,
	output int                                  fail_count,
	output int                                  pending
);
	import aef_pkg::*;

	localparam longint GAIN_Q16  = 146543;
	localparam longint Q16_UNIT  = 65536;
	localparam longint SAMPLE_HI = 32767;
	localparam longint SAMPLE_LO = -32768;
	localparam int     SHOWN_MAX = 10;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef struct {
		sample_t out_ch0;
		sample_t out_ch1;
	} echo_frame_t;

	// own copy of the delay lines and their bookkeeping
	sample_t     line_ch0 [DELAY_DEPTH];
	sample_t     line_ch1 [DELAY_DEPTH];
	int unsigned wr_pos;
	int unsigned stored;
	int unsigned delay_reg;

	echo_frame_t expected_frames [$];
	int          errors = 0;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic sample_t gain_sqrt5(input sample_t m);
		longint p;
		p = (longint'(m) * GAIN_Q16) / Q16_UNIT;
		if (p > SAMPLE_HI) begin
			p = SAMPLE_HI;
		end else if (p < SAMPLE_LO) begin
			p = SAMPLE_LO;
		end
		return sample_t'(p);
	endfunction

	function automatic echo_frame_t echo_step(input sample_t x0, input sample_t x1);
		int unsigned tap;
		int unsigned rd_pos;
		sample_t     m0;
		sample_t     m1;
		echo_frame_t f;
		tap = (delay_reg == 0) ? 1 : ((delay_reg > DELAY_DEPTH) ? DELAY_DEPTH : delay_reg);
		m0  = x0;
		m1  = x1;
		// tap is read before the write, so a full-depth delay sees the old entry
		if (stored >= tap) begin
			rd_pos = (wr_pos + DELAY_DEPTH - tap) % DELAY_DEPTH;
			m0 = sample_t'((longint'(x0) + 4 * longint'(line_ch0[rd_pos])) / 5);
			m1 = sample_t'((longint'(x1) + 4 * longint'(line_ch1[rd_pos])) / 5);
		end
		line_ch0[wr_pos] = m0;
		line_ch1[wr_pos] = m1;
		wr_pos = (wr_pos + 1) % DELAY_DEPTH;
		if (stored < DELAY_DEPTH) begin
			stored++;
		end
		f.out_ch0 = gain_sqrt5(m0);
		f.out_ch1 = gain_sqrt5(m1);
		return f;
	endfunction

	task automatic note_miss(input string field, input sample_t want, input sample_t got);
		errors++;
		if (errors <= SHOWN_MAX) begin
			$display("mismatch on %s: expected %0d, got %0d", field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		echo_frame_t want;
		echo_frame_t got;
		if (!arst_n) begin
			wr_pos    = 0;
			stored    = 0;
			delay_reg = DELAY_RESET;
			expected_frames.delete();
			pending <= 0;
		end else begin
			if (delay_we) begin
				delay_reg = delay_wdata;
			end
			if (s_tvalid && s_tready) begin
				expected_frames.push_back(echo_step(s_tdata[SAMPLE_W-1:0],
					s_tdata[2*SAMPLE_W-1:SAMPLE_W]));
			end
			if (m_tvalid && m_tready) begin
				got.out_ch0 = m_tdata[SAMPLE_W-1:0];
				got.out_ch1 = m_tdata[2*SAMPLE_W-1:SAMPLE_W];
				if (expected_frames.size() == 0) begin
					errors++;
					if (errors <= SHOWN_MAX) begin
						$display("output frame with none expected: %0d, %0d",
							got.out_ch0, got.out_ch1);
					end
				end else begin
					want = expected_frames.pop_front();
					if (got.out_ch0 !== want.out_ch0) begin
						note_miss("out_ch0", want.out_ch0, got.out_ch0);
					end
					if (got.out_ch1 !== want.out_ch1) begin
						note_miss("out_ch1", want.out_ch1, got.out_ch1);
					end
				end
			end
			pending    <= expected_frames.size();
			fail_count <= errors;
		end
	end

endmodule

### sim/tb_audio_feedback_echo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_feedback_echo
// drives stereo frames and echo delay settings into the feedback echo block
// with random gaps and stalls on both streams; a checker beside the block
// predicts and compares every output frame
// ----------------------------------------------------------------------------
module tb_audio_feedback_echo;
	import aef_pkg::*;

	localparam int LIMIT       = 400000;               // cycles before giving up
	localparam int IDLE_PCT    = 38;                   // gap / stall chance per cycle
	localparam int HOLD_CYCLES = 300;                  // long output hold-off
	localparam int PHASE_ITEMS = 150;                  // frames per cold setting
	localparam int WARM_ITEMS  = 60;                   // frames per setting once warm
	localparam int FILL_ITEMS  = 300;                  // long stretch without gaps
	localparam int TAIL_CYCLES = 8;                    // pipeline is three deep

	localparam logic [CNT_W-1:0] DELAY_ZERO    = '0;
	localparam logic [CNT_W-1:0] DELAY_REG_TOP = '1;  // above depth, clamps
	localparam logic [CNT_W-1:0] DELAY_LONG    = 14'd1000;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   delay_we    = 1'b0;
	logic [CNT_W-1:0]       delay_wdata = '0;
	logic                   s_tvalid    = 1'b0;
	logic                   s_tready;
	logic [2*SAMPLE_W-1:0]  s_tdata     = '0;      // sample_ch0, sample_ch1
	logic                   m_tvalid;
	logic                   m_tready    = 1'b0;
	logic [2*SAMPLE_W-1:0]  m_tdata;               // out_ch0, out_ch1

	// calm switches idling off on both sides; hold_req starts the long hold-off
	logic calm      = 1'b0;
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   cycle_count = 0;
	int   fail_count;
	int   pending;

	always #1 clk = ~clk;

	audio_feedback_echo dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.echo_delay_we    (delay_we),
		.echo_delay_wdata (delay_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata)
	);

	echo_frame_checker echo_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.delay_we    (delay_we),
		.delay_wdata (delay_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stalls, none while calm, and one long hold-off counted
	// here so that the block fills up and pushes back on its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			m_tready  <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// mostly full-range samples, some small ones that stay clear of the gain
	// clip, and some rail values
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: begin
				return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			end
			1, 2, 3: begin
				return 16'($urandom_range(6000)) - 16'sd3000;
			end
			default: begin
				return 16'($urandom());
			end
		endcase
	endfunction

	// one input transfer, after an optional run of idle cycles; called and
	// returning at a rising edge, so tvalid stays high between frames
	task automatic send_frame(input logic signed [SAMPLE_W-1:0] ch0,
	                          input logic signed [SAMPLE_W-1:0] ch1);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ch1, ch0};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait for every predicted frame to come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// register writes only with the block drained
	task automatic set_delay(input logic [CNT_W-1:0] value);
		wait_idle();
		delay_we    <= 1'b1;
		delay_wdata <= value;
		@(posedge clk);
		delay_we    <= 1'b0;
	endtask

	task automatic send_random(input int count, input bit with_hold);
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == count / 2) begin
				hold_req <= 1'b1;
			end
			send_frame(pick_sample(), pick_sample());
		end
	endtask

	initial begin
		// settings used while the line is still filling; the top register
		// value clamps to the full depth and never warms up here
		logic [CNT_W-1:0] cold_delays [8];
		logic [CNT_W-1:0] warm_delays [3];
		cold_delays = '{DELAY_ZERO, 14'd3, DELAY_REG_TOP, 14'd2, 14'd64, 14'd9,
		                14'd255, 14'd1};
		warm_delays = '{14'd1200, 14'd37, DELAY_ZERO};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// delay at its reset value and nothing stored: plain gain, with the
		// rails and both sides of the clip point
		send_frame(16'sh7fff, 16'sh8000);
		send_frame(16'sh8000, 16'sh7fff);
		send_frame(16'sh0000, 16'shffff);
		send_frame(16'sh0001, 16'sh0000);
		send_frame(16'sd14654, -16'sd14654);
		send_frame(16'sd14655, -16'sd14655);
		send_frame(-16'sd14656, 16'sd14656);
		send_frame(16'sh5555, 16'shaaaa);
		send_frame(16'shaaaa, 16'sh5555);

		// shortest echo: feedback from the previous frame, rails held and flipped
		set_delay(DELAY_MIN);
		send_frame(16'sh7fff, 16'sh8000);
		send_frame(16'sh7fff, 16'sh8000);
		send_frame(16'sh7fff, 16'sh8000);
		send_frame(16'sh8000, 16'sh7fff);
		send_frame(16'sh8000, 16'sh7fff);
		send_frame(16'sh0000, 16'sh0000);
		send_frame(16'shffff, 16'sh0001);
		send_frame(16'sh0001, 16'shffff);

		// random frames under several settings while the line fills; the
		// hold-off falls in the middle of one of them
		for (int p = 0; p < 8; p++) begin
			set_delay(cold_delays[p]);
			send_random(PHASE_ITEMS, p == 3);
		end

		// long echo that is already warm: one long stretch without gaps or
		// stalls on either side
		set_delay(DELAY_LONG);
		calm <= 1'b1;
		send_random(FILL_ITEMS, 1'b0);
		calm <= 1'b0;

		// enough frames stored that every setting uses the echo at once
		for (int p = 0; p < 3; p++) begin
			set_delay(warm_delays[p]);
			send_random(WARM_ITEMS, 1'b0);
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
